FILE: hdl/dan_pkg.sv
// ----------------------------------------------------------------------------
// dan_pkg - shared types and constants of the date add/normalize unit
// Field widths, divider constants, sequencer states and calendar helpers.
// ----------------------------------------------------------------------------
package dan_pkg;

   localparam int DayW     = 5;
   localparam int MonthW   = 4;
   localparam int YearW    = 14;
   localparam int AddYearW = 14;
   localparam int AddMonW  = 12;
   localparam int AddDayW  = 12;

   localparam int ReqDataW = 64;
   localparam int RspDataW = 24;

   // internal widths
   localparam int SumW   = 13;   // day and month sums
   localparam int YrW    = 17;   // working year, holds sums plus carries
   localparam int QuotW  = 14;
   localparam int RemW   = 9;
   localparam int RecipW = 22;
   localparam int ProdW  = YrW + RecipW;

   // quotient = (x * recip) >> DivShift, exact for x below 2**16
   localparam int DivShift = 25;
   localparam logic [RecipW-1:0] Recip12  = 22'd2796203;
   localparam logic [RecipW-1:0] Recip400 = 22'd83887;
   localparam logic [YrW-1:0]    Divisor12  = 17'd12;
   localparam logic [YrW-1:0]    Divisor400 = 17'd400;

   localparam logic [RemW-1:0]   LastRem400 = 9'd399;
   localparam logic [MonthW-1:0] December   = 4'd12;
   localparam logic [MonthW-1:0] January    = 4'd1;
   localparam logic [DayW-1:0]   LastDay    = 5'd31;

   typedef enum logic [0:0] {
      DIV_BY_12,
      DIV_BY_400
   } div_sel_type;

   typedef struct packed {
      logic             start;
      div_sel_type      sel;
      logic [YrW-1:0]   x;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QuotW-1:0] quot;
      logic [RemW-1:0]  remd;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD,
      ST_MOD_START,
      ST_MOD,
      ST_LOOP,
      ST_DONE
   } state_type;

   // leap test from year mod 400
   function automatic logic is_leap(input logic [RemW-1:0] r400);
      logic century;
      century = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
      return (r400 == '0) || ((r400[1:0] == 2'b00) && !century);
   endfunction

   function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                 input logic [RemW-1:0]   r400);
      logic [DayW-1:0] len;
      unique case (month)
         4'd2:                      len = is_leap(r400) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

FILE: hdl/date_add_normalize_unit.sv
// ----------------------------------------------------------------------------
// date_add_normalize_unit - Gregorian date addition with normalization
// Adds year, month and day offsets to a date and normalizes the result.
// ----------------------------------------------------------------------------
// One item is worked at a time and yields one result item. An item first
// goes through setup (month fold and year mod 400, both through one
// shared constant divider) and then through the day loop, which moves one
// month out of the day count per step. req_tready is high only while the
// unit is idle; a finished result waits in the output register and does not
// keep the next item from being taken.
// A final year above MAX_YEAR sets year_overflow and clamps to 31/12/MAX_YEAR.
// ----------------------------------------------------------------------------
module date_add_normalize_unit #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // base_day, base_month, base_year, add_years, add_months, add_days
   input  logic [dan_pkg::ReqDataW-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // result_day, result_month, result_year, year_overflow
   output logic [dan_pkg::RspDataW-1:0]  rsp_tdata
);

   localparam logic [dan_pkg::YrW-1:0]   MaxYearW   = dan_pkg::YrW'(MAX_YEAR);
   localparam logic [dan_pkg::YearW-1:0] MaxYearOut = dan_pkg::YearW'(MAX_YEAR);

   dan_pkg::state_type                state_ff, state_in;
   logic [dan_pkg::SumW-1:0]          day_ff, day_in;
   logic [dan_pkg::MonthW-1:0]        month_ff, month_in;
   logic [dan_pkg::YrW-1:0]           year_ff, year_in;
   logic [dan_pkg::RemW-1:0]          r400_ff, r400_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [dan_pkg::RspDataW-1:0]      rsp_data_ff, rsp_data_in;

   dan_pkg::div_req_type              div_req;
   dan_pkg::div_rsp_type              div_rsp;

   logic [dan_pkg::DayW-1:0]          base_day;
   logic [dan_pkg::MonthW-1:0]        base_month;
   logic [dan_pkg::YearW-1:0]         base_year;
   logic [dan_pkg::AddYearW-1:0]      add_years;
   logic [dan_pkg::AddMonW-1:0]       add_months;
   logic [dan_pkg::AddDayW-1:0]       add_days;

   logic [dan_pkg::SumW-1:0]          day_sum;
   logic [dan_pkg::SumW-1:0]          mon_sum;
   logic [dan_pkg::DayW-1:0]          mlen;
   logic                              accept;
   logic                              out_free;

   assign base_day   = req_tdata[4:0];
   assign base_month = req_tdata[8:5];
   assign base_year  = req_tdata[22:9];
   assign add_years  = req_tdata[36:23];
   assign add_months = req_tdata[48:37];
   assign add_days   = req_tdata[60:49];

   assign req_tready = (state_ff == dan_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign mlen       = dan_pkg::month_len(month_ff, r400_ff);

   dan_cdiv u_cdiv (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      r400_in      = r400_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      div_req      = '{start: 1'b0, sel: dan_pkg::DIV_BY_12, x: year_ff};

      day_sum = dan_pkg::SumW'(base_day) + dan_pkg::SumW'(add_days);
      mon_sum = dan_pkg::SumW'(base_month) + dan_pkg::SumW'(add_months);
      if (day_sum == '0) begin
         day_sum = dan_pkg::SumW'(1);
      end
      if (mon_sum == '0) begin
         mon_sum = dan_pkg::SumW'(1);
      end

      unique case (state_ff)
         dan_pkg::ST_IDLE: begin
            if (accept) begin
               day_in  = day_sum;
               year_in = dan_pkg::YrW'(base_year) + dan_pkg::YrW'(add_years);
               div_req = '{start: 1'b1, sel: dan_pkg::DIV_BY_12,
                           x: dan_pkg::YrW'(mon_sum - dan_pkg::SumW'(1))};
               state_in = dan_pkg::ST_FOLD;
            end
         end
         dan_pkg::ST_FOLD: begin
            if (div_rsp.done) begin
               month_in = div_rsp.remd[3:0] + dan_pkg::January;
               year_in  = year_ff + dan_pkg::YrW'(div_rsp.quot);
               state_in = dan_pkg::ST_MOD_START;
            end
         end
         dan_pkg::ST_MOD_START: begin
            div_req  = '{start: 1'b1, sel: dan_pkg::DIV_BY_400, x: year_ff};
            state_in = dan_pkg::ST_MOD;
         end
         dan_pkg::ST_MOD: begin
            if (div_rsp.done) begin
               r400_in  = div_rsp.remd;
               state_in = dan_pkg::ST_LOOP;
            end
         end
         dan_pkg::ST_LOOP: begin
            if (day_ff > dan_pkg::SumW'(mlen)) begin
               day_in = day_ff - dan_pkg::SumW'(mlen);
               if (month_ff == dan_pkg::December) begin
                  month_in = dan_pkg::January;
                  year_in  = year_ff + dan_pkg::YrW'(1);
                  r400_in  = (r400_ff == dan_pkg::LastRem400) ? '0
                                                               : r400_ff + 9'd1;
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end else begin
               state_in = dan_pkg::ST_DONE;
            end
         end
         dan_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (year_ff > MaxYearW) begin
                  rsp_data_in = {1'b1, MaxYearOut, dan_pkg::December, dan_pkg::LastDay};
               end else begin
                  rsp_data_in = {1'b0, year_ff[dan_pkg::YearW-1:0], month_ff,
                                 day_ff[dan_pkg::DayW-1:0]};
               end
               state_in = dan_pkg::ST_IDLE;
            end
         end
         default: state_in = dan_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dan_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      day_ff      <= day_in;
      month_ff    <= month_in;
      year_ff     <= year_in;
      r400_ff     <= r400_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_loop_month: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dan_pkg::ST_LOOP) |-> (month_ff >= 4'd1) && (month_ff <= 4'd12))
      else $error("month out of range in day loop");

   a_loop_r400: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dan_pkg::ST_LOOP) |-> (r400_ff <= dan_pkg::LastRem400))
      else $error("year mod 400 out of range");

   a_done_day: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dan_pkg::ST_DONE) |-> (day_ff >= 13'd1) && (day_ff <= 13'd31))
      else $error("day not normalized at finish");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == dan_pkg::ST_FOLD) || (state_ff == dan_pkg::ST_MOD))
      else $error("divider result outside a wait state");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == dan_pkg::ST_DONE) && (state_in == dan_pkg::ST_IDLE))
         |=> rsp_valid_ff)
      else $error("finished item not presented");

endmodule

FILE: hdl/dan_cdiv.sv
// ----------------------------------------------------------------------------
// dan_cdiv - shared divide-by-constant unit
// Quotient and remainder by 12 or by 400 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module dan_cdiv (
   input  logic                 clock,
   input  logic                 reset,
   input  dan_pkg::div_req_type req,
   output dan_pkg::div_rsp_type rsp
);

   logic                         v0_ff, v0_in;
   logic                         v1_ff, v1_in;
   logic                         v2_ff, v2_in;
   logic [dan_pkg::YrW-1:0]      x0_ff, x0_in;
   logic [dan_pkg::YrW-1:0]      x1_ff, x1_in;
   dan_pkg::div_sel_type         sel0_ff, sel0_in;
   dan_pkg::div_sel_type         sel1_ff, sel1_in;
   logic [dan_pkg::ProdW-1:0]    prod_ff, prod_in;
   logic [dan_pkg::QuotW-1:0]    quot_ff, quot_in;
   logic [dan_pkg::RemW-1:0]     remd_ff, remd_in;

   logic [dan_pkg::RecipW-1:0]   recip;
   logic [dan_pkg::YrW-1:0]      divisor;
   logic [dan_pkg::YrW-1:0]      qd;

   always_comb begin
      unique case (sel0_ff)
         dan_pkg::DIV_BY_12:  recip = dan_pkg::Recip12;
         dan_pkg::DIV_BY_400: recip = dan_pkg::Recip400;
         default:             recip = dan_pkg::Recip12;
      endcase
      unique case (sel1_ff)
         dan_pkg::DIV_BY_12:  divisor = dan_pkg::Divisor12;
         dan_pkg::DIV_BY_400: divisor = dan_pkg::Divisor400;
         default:             divisor = dan_pkg::Divisor12;
      endcase

      v0_in   = req.start;
      x0_in   = req.x;
      sel0_in = req.sel;

      v1_in   = v0_ff;
      x1_in   = x0_ff;
      sel1_in = sel0_ff;
      prod_in = dan_pkg::ProdW'(x0_ff) * dan_pkg::ProdW'(recip);

      v2_in   = v1_ff;
      quot_in = dan_pkg::QuotW'(prod_ff >> dan_pkg::DivShift);
      qd      = dan_pkg::YrW'(quot_in) * divisor;
      remd_in = dan_pkg::RemW'(x1_ff - qd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff   <= x0_in;
      sel0_ff <= sel0_in;
      x1_ff   <= x1_in;
      sel1_ff <= sel1_in;
      prod_ff <= prod_in;
      quot_ff <= quot_in;
      remd_ff <= remd_in;
   end

   assign rsp.done = v2_ff;
   assign rsp.quot = quot_ff;
   assign rsp.remd = remd_ff;

endmodule

FILE: verif/tb_date_add_normalize_unit.sv
// ----------------------------------------------------------------------------
// tb_date_add_normalize_unit - self-checking bench for date add/normalize
// Drives date items with added years, months and days through the request
// stream and checks every result item against a cycle-free calendar model.
// Covers field extremes, zero day/month/year, month folding, leap rules,
// year overflow clamping, random idling and a long result back-pressure.
// ----------------------------------------------------------------------------
module tb_date_add_normalize_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MaxYear = 9999;

   // request item, first field in the low bits
   typedef struct packed {
      logic [2:0]                     pad;
      logic [dan_pkg::AddDayW-1:0]    add_days;
      logic [dan_pkg::AddMonW-1:0]    add_months;
      logic [dan_pkg::AddYearW-1:0]   add_years;
      logic [dan_pkg::YearW-1:0]      base_year;
      logic [dan_pkg::MonthW-1:0]     base_month;
      logic [dan_pkg::DayW-1:0]       base_day;
   } date_request_type;

   typedef struct packed {
      logic                           overflow;
      logic [dan_pkg::YearW-1:0]      year;
      logic [dan_pkg::MonthW-1:0]     month;
      logic [dan_pkg::DayW-1:0]       day;
   } date_result_type;

   class date_add_scoreboard;
      date_result_type expected_dates[$];
      int           errors;
      int           dates_sent;
      int           dates_checked;
      int           overflows;

      function new();
         errors        = 0;
         dates_sent    = 0;
         dates_checked = 0;
         overflows     = 0;
      endfunction

      function automatic bit leap(int unsigned y);
         return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
      endfunction

      function automatic int unsigned month_days(int unsigned m, int unsigned y);
         case (m)
            2:             return leap(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
         endcase
      endfunction

      function automatic date_result_type normalized_date(date_request_type r);
         int unsigned  day;
         int unsigned  month;
         int unsigned  year;
         date_result_type res;
         day   = int'(r.base_day) + int'(r.add_days);
         month = int'(r.base_month) + int'(r.add_months);
         year  = int'(r.base_year) + int'(r.add_years);
         res.overflow = 1'b0;
         if (day == 0) day = 1;
         if (month == 0) month = 1;
         if (month > 12) begin
            year  += (month - 1) / 12;
            month  = (month - 1) % 12 + 1;
         end
         while (day > month_days(month, year)) begin
            day -= month_days(month, year);
            month++;
            if (month == 13) begin
               month = 1;
               year++;
            end
         end
         if (year > MaxYear) begin
            res.overflow = 1'b1;
            day   = 31;
            month = 12;
            year  = MaxYear;
         end
         res.day   = day[dan_pkg::DayW-1:0];
         res.month = month[dan_pkg::MonthW-1:0];
         res.year  = year[dan_pkg::YearW-1:0];
         return res;
      endfunction

      function void note_date(date_request_type r);
         date_result_type exp;
         exp = normalized_date(r);
         expected_dates.push_back(exp);
         dates_sent++;
         if (exp.overflow) overflows++;
      endfunction

      function void check_date(date_result_type got);
         date_result_type exp;
         dates_checked++;
         if (expected_dates.size() == 0) begin
            $error("result item with no date pending: %0d/%0d/%0d ovf %0b",
                   got.day, got.month, got.year, got.overflow);
            errors++;
            return;
         end
         exp = expected_dates.pop_front();
         if (got.day !== exp.day) begin
            $error("result_day: expected %0d, got %0d", exp.day, got.day);
            errors++;
         end
         if (got.month !== exp.month) begin
            $error("result_month: expected %0d, got %0d", exp.month, got.month);
            errors++;
         end
         if (got.year !== exp.year) begin
            $error("result_year: expected %0d, got %0d", exp.year, got.year);
            errors++;
         end
         if (got.overflow !== exp.overflow) begin
            $error("year_overflow: expected %0b, got %0b", exp.overflow, got.overflow);
            errors++;
         end
      endfunction
   endclass

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [dan_pkg::ReqDataW-1:0]   req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [dan_pkg::RspDataW-1:0]   rsp_tdata;

   bit                 idling_on     = 1'b1;
   bit                 hold_rsp      = 1'b0;
   date_add_scoreboard board         = new();

   date_add_normalize_unit #(
      .MAX_YEAR(MaxYear)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (600) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_date(date_result_type'(rsp_tdata));
   end

   function automatic date_request_type make_date(int d, int m, int y, int ay, int am,
                                                  int ad);
      date_request_type r;
      r.pad        = '0;
      r.base_day   = d[dan_pkg::DayW-1:0];
      r.base_month = m[dan_pkg::MonthW-1:0];
      r.base_year  = y[dan_pkg::YearW-1:0];
      r.add_years  = ay[dan_pkg::AddYearW-1:0];
      r.add_months = am[dan_pkg::AddMonW-1:0];
      r.add_days   = ad[dan_pkg::AddDayW-1:0];
      return r;
   endfunction

   function automatic date_request_type random_date();
      int kind;
      int century_years[8];
      int ad;
      century_years = '{0, 400, 1600, 1900, 2000, 2100, 2023, 2024};
      kind = $urandom_range(0, 9);
      ad = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 60);
      if (kind <= 5) begin
         return make_date($urandom_range(1, 31), $urandom_range(1, 12),
                          $urandom_range(1, 9999), $urandom_range(0, 300),
                          $urandom_range(0, 4095), ad);
      end else if (kind == 6) begin
         return make_date($urandom_range(1, 31), $urandom_range(1, 12),
                          $urandom_range(9900, 9999), $urandom_range(0, 100),
                          $urandom_range(0, 1200), ad);
      end else if (kind == 7) begin
         return make_date($urandom_range(27, 31), $urandom_range(1, 3),
                          century_years[$urandom_range(0, 7)], $urandom_range(0, 4),
                          $urandom_range(0, 2), $urandom_range(0, 400));
      end
      return make_date($urandom_range(0, 31), $urandom_range(0, 15),
                       $urandom_range(0, 16383), $urandom_range(0, 16383),
                       $urandom_range(0, 4095), $urandom_range(0, 4095));
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_date(date_request_type r);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_date(r);
      @(negedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_date(make_date(1, 1, 1, 0, 0, 0));
      send_date(make_date(0, 0, 0, 0, 0, 0));
      send_date(make_date(29, 2, 0, 0, 0, 0));
      send_date(make_date(31, 12, 9999, 0, 0, 0));
      send_date(make_date(31, 12, 9999, 0, 0, 1));
      send_date(make_date(1, 1, 10000, 0, 0, 0));
      send_date(make_date(1, 1, 0, 9999, 0, 0));
      send_date(make_date(1, 1, 1, 9999, 0, 0));
      send_date(make_date(10, 15, 2020, 0, 0, 0));
      send_date(make_date(5, 12, 2020, 0, 12, 0));
      send_date(make_date(31, 4, 2023, 0, 0, 0));
      send_date(make_date(29, 2, 2000, 0, 0, 0));
      send_date(make_date(29, 2, 1900, 0, 0, 0));
      send_date(make_date(29, 2, 2024, 0, 0, 0));
      send_date(make_date(29, 2, 2023, 0, 0, 0));
      send_date(make_date(28, 2, 2000, 0, 0, 1));
      send_date(make_date(31, 12, 1999, 0, 0, 1));
      send_date(make_date(1, 1, 2000, 0, 0, 4095));
      send_date(make_date(1, 1, 1, 0, 4095, 0));
      send_date(make_date(31, 15, 16383, 16383, 4095, 4095));
      send_date(make_date(0, 0, 0, 0, 4095, 4095));

      for (int i = 0; i < 390; i++) begin
         if (i == 20) hold_rsp = 1'b1;
         if (i == 310) idling_on = 1'b0;
         send_date(random_date());
      end
      req_tvalid <= 1'b0;

      while (board.expected_dates.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Covered %0d date items (%0d clamped on year overflow), %0d results checked,",
               board.dates_sent, board.overflows, board.dates_checked);
      $display("including field extremes, leap centuries and a long result stall.");
      if (board.errors == 0 && board.expected_dates.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
